>>> design/tsdt_pkg.sv
// ----------------------------------------------------------------------------
// tsdt_pkg
// Types and constants for the transport-stream timestamp duration tracker.
// ----------------------------------------------------------------------------
package tsdt_pkg;

  localparam int PTS_W = 33;
  localparam int PCR_W = 42;
  localparam int DUR_W = 43;
  localparam int PID_W = 13;
  localparam int DSOR_W = 16;

  localparam logic [PCR_W-1:0] PCR_RANGE = 42'd2576980377600;
  localparam logic [PCR_W-1:0] PCR_HALF = 42'd1288490188800;
  localparam logic [PTS_W-1:0] PTS_HALF = 33'h100000000;

  localparam logic [DSOR_W-1:0] DSOR_PTS = 16'd90;
  localparam logic [DSOR_W-1:0] DSOR_PCR = 16'd27000;

  // ceil(2^shift / divisor), exact for dividends below 2^31
  localparam logic [31:0] RCP_PTS = 32'd3054198967;
  localparam logic [31:0] RCP_PCR = 32'd2606249785;
  localparam int RCP_SH_PTS = 38;
  localparam int RCP_SH_PCR = 46;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_PTS = 2'd1;
  localparam logic [1:0] SRC_PCR = 2'd2;

  localparam logic [1:0] MODE_PACKET = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_FORGET = 2'd2;

  typedef enum logic [1:0] {
    OP_PACKET = 2'd0,
    OP_QUERY  = 2'd1,
    OP_FORGET = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [PID_W-1:0] pid;
    logic             pcr_en;
    logic [PCR_W-1:0] pcr;
    logic             pts_en;
    logic [PTS_W-1:0] pts;
  } item_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

>>> design/tsdt_ram.sv
// ----------------------------------------------------------------------------
// tsdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsdt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/tsdt_front.sv
// ----------------------------------------------------------------------------
// tsdt_front
// Accepts requests, decodes the mode and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tsdt_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 mode,
  input  logic [tsdt_pkg::PID_W-1:0] packet_pid,
  input  logic                       has_pcr,
  input  logic [tsdt_pkg::PCR_W-1:0] pcr_value,
  input  logic                       has_pts,
  input  logic [tsdt_pkg::PTS_W-1:0] pts_value,
  input  logic                       pid_tracked,
  input  tsdt_pkg::back_ctl_t        ctl,
  output logic                       q_valid,
  output tsdt_pkg::item_t            q_item
);

  tsdt_pkg::item_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            acc;
  logic            keep;
  logic            deq;
  tsdt_pkg::item_t in_item;

  assign full    = (count == 2'd2) || ctl.clearing;
  assign acc     = push && !full;
  assign q_valid = (count != 2'd0);
  assign q_item  = slots[rd_ptr];
  assign deq     = ctl.pop && q_valid;

  always_comb begin
    in_item        = '0;
    in_item.pid    = packet_pid;
    in_item.pcr    = pcr_value;
    in_item.pts    = pts_value;
    in_item.pcr_en = has_pcr;
    in_item.pts_en = has_pts && pid_tracked;
    keep           = 1'b1;
    case (mode)
      tsdt_pkg::MODE_PACKET: in_item.op = tsdt_pkg::OP_PACKET;
      tsdt_pkg::MODE_QUERY:  in_item.op = tsdt_pkg::OP_QUERY;
      tsdt_pkg::MODE_FORGET: in_item.op = tsdt_pkg::OP_FORGET;
      default: begin
        // drop the unused mode here
        in_item.op = tsdt_pkg::OP_PACKET;
        keep       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc && keep) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (acc && keep) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(acc && keep) - 2'(deq);
    end
  end

endmodule

>>> design/tsdt_div.sv
// ----------------------------------------------------------------------------
// tsdt_div
// Divider by 90 or 27000 through reciprocal multiplication, 16 quotient bits
// per digit in a multiply step and a remainder step, saturating.
// ----------------------------------------------------------------------------
module tsdt_div #(
  parameter int NUM_W = 58
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       sel_pcr,
  input  logic [NUM_W-1:0]           num,
  output logic                       done,
  output logic [tsdt_pkg::DUR_W-1:0] quo
);

  localparam int DIGITS = (NUM_W + 15) / 16;
  localparam int PAD_W  = DIGITS * 16;
  localparam int CNT_W  = $clog2(DIGITS + 1);
  localparam int REM_W  = 15;

  logic                        busy;
  logic                        phase;
  logic                        sel;
  logic [CNT_W-1:0]            cnt;
  logic [PAD_W-1:0]            num_sh;
  logic [PAD_W-1:0]            q;
  logic [REM_W-1:0]            rem;
  logic [30:0]                 x;
  logic [30:0]                 x_hold;
  logic [62:0]                 prod;
  logic [31:0]                 rcp;
  logic [tsdt_pkg::DSOR_W-1:0] dsor;
  logic [15:0]                 qd;
  logic [30:0]                 rem_full;

  // remainder below the divisor, so each partial dividend stays under 2^31
  assign x        = {rem, num_sh[PAD_W-1 -: 16]};
  assign rcp      = sel ? tsdt_pkg::RCP_PCR : tsdt_pkg::RCP_PTS;
  assign dsor     = sel ? tsdt_pkg::DSOR_PCR : tsdt_pkg::DSOR_PTS;
  assign qd       = sel ? prod[tsdt_pkg::RCP_SH_PCR +: 16] : prod[tsdt_pkg::RCP_SH_PTS +: 16];
  assign rem_full = x_hold - 31'(qd) * 31'(dsor);
  assign quo      = (|q[PAD_W-1:tsdt_pkg::DUR_W]) ? '1 : q[tsdt_pkg::DUR_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= '0;
      num_sh <= PAD_W'(num);
      q      <= '0;
      sel    <= sel_pcr;
    end else if (busy && !phase) begin
      x_hold <= x;
      prod   <= 63'(x) * 63'(rcp);
      num_sh <= num_sh << 16;
    end else if (busy && phase) begin
      rem <= rem_full[REM_W-1:0];
      q   <= {q[PAD_W-17:0], qd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && phase && (cnt == CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= CNT_W'(DIGITS);
      end else if (busy) begin
        phase <= !phase;
        if (phase) begin
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

endmodule

>>> design/tsdt_back.sv
// ----------------------------------------------------------------------------
// tsdt_back
// Runs queued requests: PCR tracker, per-PID PTS read-modify-write, entry
// clearing on forget and duration queries through the shared divider.
// ----------------------------------------------------------------------------
module tsdt_back #(
  parameter int PID_BITS  = 13,
  parameter int WRAP_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  tsdt_pkg::item_t            q_item,
  output tsdt_pkg::back_ctl_t        ctl,
  output logic                       empty,
  input  logic                       pop,
  output logic [tsdt_pkg::DUR_W-1:0] duration_ms,
  output logic [1:0]                 time_source
);

  localparam int PTS_W = tsdt_pkg::PTS_W;
  localparam int PCR_W = tsdt_pkg::PCR_W;
  localparam int ENT_W = 1 + 2 * PTS_W + WRAP_BITS;
  localparam int NUM_W = WRAP_BITS + 9 + PTS_W;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RMW   = 6'b000100,
    ST_QRD   = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [PID_BITS-1:0]  clr_addr;
  logic [PID_BITS-1:0]  cur_pid;
  logic [PTS_W-1:0]     cur_pts;
  logic [PID_BITS-1:0]  pid;

  logic [PID_BITS-1:0]  pcr_src;
  logic                 pcr_seen;
  logic [PCR_W-1:0]     pcr_first;
  logic [PCR_W-1:0]     pcr_last;
  logic [WRAP_BITS-1:0] pcr_wraps;
  logic [PID_BITS-1:0]  src_eff;
  logic                 pcr_hit;

  logic                 ram_we;
  logic [PID_BITS-1:0]  ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [ENT_W-1:0]     ram_rdata;
  logic                 e_seen;
  logic [PTS_W-1:0]     e_first;
  logic [PTS_W-1:0]     e_last;
  logic [WRAP_BITS-1:0] e_wraps;
  logic [PTS_W-1:0]     n_first;
  logic [PTS_W-1:0]     n_last;
  logic [WRAP_BITS-1:0] n_wraps;

  logic                 div_start;
  logic                 div_sel_pcr;
  logic [NUM_W-1:0]     div_num;
  logic                 div_done;
  logic [tsdt_pkg::DUR_W-1:0] div_quo;
  logic [NUM_W-1:0]     pcr_wide;
  logic [1:0]           res_src;
  logic [tsdt_pkg::DUR_W-1:0] res_dur;
  logic                 out_valid;
  logic                 out_load;

  assign pid = q_item.pid[PID_BITS-1:0];
  assign {e_seen, e_first, e_last, e_wraps} = ram_rdata;
  assign empty = !out_valid;
  assign out_load = (state == ST_OUT) && (!out_valid || pop);
  assign ctl.clearing = (state == ST_CLEAR);
  assign ctl.pop = (state == ST_IDLE) && q_valid;

  tsdt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(1 << PID_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(pid),
    .rdata(ram_rdata)
  );

  tsdt_div #(
    .NUM_W(NUM_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .sel_pcr(div_sel_pcr),
    .num    (div_num),
    .done   (div_done),
    .quo    (div_quo)
  );

  // PCR source: first PID carrying a PCR; null PID keeps it open
  assign src_eff = (pcr_src == '1) ? pid : pcr_src;
  assign pcr_hit = ctl.pop && (q_item.op == tsdt_pkg::OP_PACKET) && q_item.pcr_en
                   && (pid == src_eff) && (q_item.pcr < tsdt_pkg::PCR_RANGE);

  // PTS update of the entry read in the previous cycle
  always_comb begin
    n_first = e_first;
    n_last  = e_last;
    n_wraps = e_wraps;
    if (!e_seen) begin
      n_first = cur_pts;
      n_last  = cur_pts;
      n_wraps = '0;
    end else if (cur_pts >= e_last) begin
      n_last = cur_pts;
    end else if ((e_last - cur_pts) > tsdt_pkg::PTS_HALF) begin
      n_last = cur_pts;
      if (e_wraps != '1) begin
        n_wraps = e_wraps + WRAP_BITS'(1);
      end
    end
  end

  // wraps * 300; shifted left by PTS_W in the query for the PCR span (wraps * 300 * 2^33)
  assign pcr_wide = (NUM_W'(pcr_wraps) << 8) + (NUM_W'(pcr_wraps) << 5)
                  + (NUM_W'(pcr_wraps) << 3) + (NUM_W'(pcr_wraps) << 2);

  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = cur_pid;
    ram_wdata   = '0;
    div_start   = 1'b0;
    div_sel_pcr = 1'b0;
    div_num     = '0;
    state_next  = state;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            tsdt_pkg::OP_PACKET: begin
              if (q_item.pts_en) begin
                state_next = ST_RMW;
              end
            end
            tsdt_pkg::OP_QUERY: state_next = ST_QRD;
            tsdt_pkg::OP_FORGET: begin
              ram_we    = 1'b1;
              ram_waddr = pid;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_RMW: begin
        ram_we     = 1'b1;
        ram_wdata  = {1'b1, n_first, n_last, n_wraps};
        state_next = ST_IDLE;
      end
      ST_QRD: begin
        if (e_seen) begin
          div_start  = 1'b1;
          div_num    = NUM_W'({e_wraps, e_last}) - NUM_W'(e_first);
          state_next = ST_DIV;
        end else if (pcr_seen) begin
          div_start   = 1'b1;
          div_sel_pcr = 1'b1;
          div_num     = (pcr_wide << PTS_W) + NUM_W'(pcr_last) - NUM_W'(pcr_first);
          state_next  = ST_DIV;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      pcr_src   <= '1;
      pcr_seen  <= 1'b0;
      pcr_first <= '0;
      pcr_last  <= '0;
      pcr_wraps <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + PID_BITS'(1);
      end
      if (ctl.pop && (q_item.op == tsdt_pkg::OP_PACKET) && q_item.pcr_en) begin
        pcr_src <= src_eff;
      end
      if (pcr_hit) begin
        if (!pcr_seen) begin
          pcr_seen  <= 1'b1;
          pcr_first <= q_item.pcr;
          pcr_last  <= q_item.pcr;
          pcr_wraps <= '0;
        end else if (q_item.pcr >= pcr_last) begin
          pcr_last <= q_item.pcr;
        end else if ((pcr_last - q_item.pcr) > tsdt_pkg::PCR_HALF) begin
          pcr_last <= q_item.pcr;
          if (pcr_wraps != '1) begin
            pcr_wraps <= pcr_wraps + WRAP_BITS'(1);
          end
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cur_pid <= pid;
      cur_pts <= q_item.pts;
    end
    if (state == ST_QRD) begin
      res_dur <= '0;
      res_src <= e_seen ? tsdt_pkg::SRC_PTS :
                 (pcr_seen ? tsdt_pkg::SRC_PCR : tsdt_pkg::SRC_NONE);
    end else if (div_done) begin
      res_dur <= div_quo;
    end
    if (out_load) begin
      duration_ms <= res_dur;
      time_source <= res_src;
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (state == ST_IDLE))
    else $error("queue popped outside idle");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide state");
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (state == ST_CLEAR))
    else $error("reset did not start clearing pass");
`endif

endmodule

>>> design/ts_timestamp_duration_tracker.sv
// ----------------------------------------------------------------------------
// ts_timestamp_duration_tracker
// Tracks PCR and per-PID PTS spans of a transport stream and answers
// duration queries in milliseconds.
// ----------------------------------------------------------------------------
// channel   handshake     payload
// request   push / full   mode, packet_pid, has_pcr, pcr_value, has_pts,
//                         pts_value, pid_tracked
// result    empty / pop   duration_ms, time_source
//
// After reset every PID table entry is cleared with full held.
// A packet with a tracked PTS is a table read, then a write back; other
// packets and forgets are done in the idle state as they are popped.
// A query reads the table, then runs the reciprocal divider (skipped when no
// source is known) over ceil((WRAP_BITS+42)/16) 16-bit digits.
// A two-entry request queue keeps accepting while a result waits for pop.
// ----------------------------------------------------------------------------
module ts_timestamp_duration_tracker #(
  parameter int PID_BITS  = 13,
  parameter int WRAP_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [12:0] packet_pid,
  input  logic        has_pcr,
  input  logic [41:0] pcr_value,
  input  logic        has_pts,
  input  logic [32:0] pts_value,
  input  logic        pid_tracked,
  output logic        empty,
  input  logic        pop,
  output logic [42:0] duration_ms,
  output logic [1:0]  time_source
);

  tsdt_pkg::back_ctl_t ctl;
  tsdt_pkg::item_t     q_item;
  logic                q_valid;

  tsdt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .mode       (mode),
    .packet_pid (packet_pid),
    .has_pcr    (has_pcr),
    .pcr_value  (pcr_value),
    .has_pts    (has_pts),
    .pts_value  (pts_value),
    .pid_tracked(pid_tracked),
    .ctl        (ctl),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  tsdt_back #(
    .PID_BITS (PID_BITS),
    .WRAP_BITS(WRAP_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .ctl        (ctl),
    .empty      (empty),
    .pop        (pop),
    .duration_ms(duration_ms),
    .time_source(time_source)
  );

endmodule
